// ===== rtl/core/glms_pkg.sv =====
// Shared types and constants of the grid local minimum block.
// No dependencies; the cell, judge and top files of the block refer to it by scoped names.

package glms_pkg;

  // Height digits and the out-of-grid value
  localparam int unsigned HEIGHT_W = 4;
  typedef logic [HEIGHT_W-1:0] height_t;
  localparam height_t EDGE_HEIGHT = height_t'(9);

  // Register widths, reset values and indexes
  localparam int unsigned COLS_REG_W = 8;
  localparam int unsigned ROWS_REG_W = 16;
  localparam logic [COLS_REG_W-1:0] COLS_RESET = COLS_REG_W'(100);
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = ROWS_REG_W'(100);
  localparam logic REG_GRID_COLUMNS = 1'b0;
  localparam logic REG_GRID_ROWS    = 1'b1;

  // Accumulator and result widths
  localparam int unsigned COUNT_W     = 24;
  localparam int unsigned LOW_COUNT_W = 23;
  localparam int unsigned RISK_W      = 27;

  // Control of one window cell: load takes the fill value, shift takes the neighbor
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // One cell under test and its four neighbors
  typedef struct packed {
    height_t center;
    height_t up;
    height_t down;
    height_t left;
    height_t right;
  } nbr_t;

endpackage

// ===== rtl/core/glms_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module glms_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while the read is off
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/glms_cell.sv =====
// One cell of the neighborhood window: holds a height and passes it on.
// Depends on glms_pkg for the height type and the cell control struct.

module glms_cell (
  input  logic                clk_i,
  input  glms_pkg::cell_ctrl_t ctrl_i,
  input  glms_pkg::height_t   nb_i,
  input  glms_pkg::height_t   fill_i,
  output glms_pkg::height_t   data_o
);

  glms_pkg::height_t data_q, data_d;

  // Load a fresh value, or take the neighbor's on a shift, else hold
  always_comb begin
    data_d = data_q;
    priority if (ctrl_i.load) begin
      data_d = fill_i;
    end else if (ctrl_i.shift) begin
      data_d = nb_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/core/glms_judge.sv =====
// Low-point test of one cell against its four neighbors, with its risk weight.
// Depends on glms_pkg for the neighbor struct.

module glms_judge (
  input  logic                en_i,
  input  glms_pkg::nbr_t      nbr_i,
  output logic                low_o,
  output logic [glms_pkg::HEIGHT_W:0] risk_o
);

  logic all_higher;

  // Require every neighbor strictly above the center
  assign all_higher = (nbr_i.up > nbr_i.center) && (nbr_i.down > nbr_i.center) &&
                      (nbr_i.left > nbr_i.center) && (nbr_i.right > nbr_i.center);

  assign low_o  = en_i && all_higher;
  assign risk_o = low_o ? ({1'b0, nbr_i.center} + (glms_pkg::HEIGHT_W+1)'(1))
                        : '0;

endmodule

// ===== rtl/core/grid_local_minimum_sum.sv =====
// One height word per cycle while in_ready_o is high; a frame result enters the
// output queue when the last word of the frame is accepted.
// The two line buffers give the window cells two reads and one write per cycle.
// After each register write, in_ready_o stays low through ST_FILL0 to ST_FILL4 while
// the window cells reload from the line buffers. Reset clears counters, accumulators
// and the output queue and sets both registers to 100; line buffer contents are kept.

module grid_local_minimum_sum #(
  parameter int unsigned MAX_COLUMNS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Height stream
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  height_i,
  // Frame results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [22:0] low_count_o,
  output logic [26:0] risk_sum_o,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CW = $clog2(MAX_COLUMNS);
  localparam int unsigned XW = (CW > glms_pkg::COLS_REG_W) ? CW : glms_pkg::COLS_REG_W;
  localparam logic [CW-1:0] COL_LAST_MAX = CW'(MAX_COLUMNS - 1);
  localparam int unsigned RW = glms_pkg::ROWS_REG_W;
  localparam int unsigned IW = glms_pkg::HEIGHT_W + 3;

  typedef enum logic [5:0] {
    ST_RUN   = 6'b000001,
    ST_FILL0 = 6'b000010,
    ST_FILL1 = 6'b000100,
    ST_FILL2 = 6'b001000,
    ST_FILL3 = 6'b010000,
    ST_FILL4 = 6'b100000
  } fill_state_e;

  typedef struct packed {
    logic [glms_pkg::LOW_COUNT_W-1:0] low_count;
    logic [glms_pkg::RISK_W-1:0]      risk_sum;
  } result_t;

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  logic [glms_pkg::COLS_REG_W-1:0] grid_columns_q;
  logic [RW-1:0]                   grid_rows_q;
  logic                            cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_columns_q <= glms_pkg::COLS_RESET;
      grid_rows_q    <= glms_pkg::ROWS_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        glms_pkg::REG_GRID_COLUMNS: grid_columns_q <= pwdata[glms_pkg::COLS_REG_W-1:0];
        glms_pkg::REG_GRID_ROWS:    grid_rows_q    <= pwdata[RW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      glms_pkg::REG_GRID_COLUMNS: prdata = 32'(grid_columns_q);
      glms_pkg::REG_GRID_ROWS:    prdata = 32'(grid_rows_q);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Position in the frame
  // ---------------------------------------------------------------------------
  logic [CW-1:0] column_index_q, column_index_d;
  logic [RW-1:0] row_index_q, row_index_d;
  logic [XW-1:0] gc_x, gm1_x;
  logic [CW-1:0] cols_m1, col, next_col;
  logic [RW-1:0] rows_m1;
  logic          last_col, last_row, frame_end;
  logic          row_ge1, row_ge2, col_ge1, col_ge2;
  logic          cur_bank, next_bank;
  logic          in_accept;

  // Clamp the column count to 1..MAX_COLUMNS and the row count to at least one
  assign gc_x    = XW'(grid_columns_q);
  assign gm1_x   = gc_x - XW'(1);
  assign cols_m1 = (grid_columns_q == '0) ? '0 :
                   (gm1_x > XW'(COL_LAST_MAX)) ? COL_LAST_MAX : gm1_x[CW-1:0];
  assign rows_m1 = (grid_rows_q == '0) ? '0 : grid_rows_q - RW'(1);

  assign col       = (column_index_q > cols_m1) ? cols_m1 : column_index_q;
  assign last_col  = (col == cols_m1);
  assign last_row  = (row_index_q >= rows_m1);
  assign frame_end = last_col && last_row;
  assign row_ge1   = (row_index_q != '0);
  assign row_ge2   = (row_index_q[RW-1:1] != '0);
  assign col_ge1   = (col != '0);
  assign col_ge2   = ({1'b0, col} >= (CW+1)'(2));
  assign cur_bank  = row_index_q[0];

  // Advance column, then row, wrapping to the frame start
  always_comb begin
    next_col       = last_col ? '0 : col + CW'(1);
    column_index_d = next_col;
    row_index_d    = row_index_q;
    if (last_col) begin
      row_index_d = last_row ? '0 : row_index_q + RW'(1);
    end
  end
  assign next_bank = row_index_d[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_index_q <= '0;
      row_index_q    <= '0;
    end else if (in_accept) begin
      column_index_q <= column_index_d;
      row_index_q    <= row_index_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Window reload sequencer
  // ---------------------------------------------------------------------------
  fill_state_e state_q, state_d;

  always_comb begin
    unique case (state_q)
      ST_FILL0: state_d = ST_FILL1;
      ST_FILL1: state_d = ST_FILL2;
      ST_FILL2: state_d = ST_FILL3;
      ST_FILL3: state_d = ST_FILL4;
      ST_FILL4: state_d = ST_RUN;
      default:  state_d = ST_RUN;
    endcase
    if (cfg_write) begin
      state_d = ST_FILL0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line buffers: one bank per row parity
  // ---------------------------------------------------------------------------
  glms_pkg::height_t height;
  glms_pkg::height_t rd_data [2];
  glms_pkg::height_t d_ram, c_ram;
  logic [CW-1:0]     rd_base, cur_raddr, prev_raddr;
  logic              rd_en, rd_bank;

  assign height = height_i;

  // Pick the read base: next position on a word, reload steps otherwise
  always_comb begin
    unique case (state_q)
      ST_FILL0: rd_base = '0;
      ST_FILL1: rd_base = CW'(1);
      ST_FILL2: rd_base = col - CW'(2);
      ST_FILL3: rd_base = col - CW'(1);
      ST_FILL4: rd_base = col;
      default:  rd_base = next_col;
    endcase
  end

  assign cur_raddr  = rd_base;
  assign prev_raddr = rd_base + CW'(1);
  assign rd_en      = in_accept || (state_q != ST_RUN);
  assign rd_bank    = in_accept ? next_bank : cur_bank;

  for (genvar b = 0; b < 2; b++) begin : g_bank
    glms_ram #(
      .WIDTH(glms_pkg::HEIGHT_W),
      .DEPTH(MAX_COLUMNS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (in_accept && (cur_bank == 1'(b))),
      .waddr_i (col),
      .wdata_i (height),
      .re_i    (rd_en),
      .raddr_i ((rd_bank == 1'(b)) ? cur_raddr : prev_raddr),
      .rdata_o (rd_data[b])
    );
  end

  // Row two above from the current bank, previous row from the other
  assign d_ram = rd_data[cur_bank];
  assign c_ram = rd_data[~cur_bank];

  // ---------------------------------------------------------------------------
  // Row start holds: first two cells of the row being written
  // ---------------------------------------------------------------------------
  glms_pkg::height_t h0_q, h1_q, c_hold_q, b_rowend;
  glms_pkg::height_t c_eff;
  logic              row_start_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FILL1) begin
      h0_q <= d_ram;
    end else if (in_accept && (col == '0)) begin
      h0_q <= height;
    end
    if (state_q == ST_FILL2) begin
      h1_q <= d_ram;
    end else if (in_accept && (col == CW'(1))) begin
      h1_q <= height;
    end
    if (in_accept && last_col) begin
      c_hold_q <= (col == CW'(1)) ? height : h1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_start_q <= 1'b0;
    end else if (state_q != ST_RUN) begin
      row_start_q <= 1'b0;
    end else if (in_accept) begin
      row_start_q <= last_col;
    end
  end

  assign b_rowend = (col == '0) ? height : h0_q;
  assign c_eff    = row_start_q ? c_hold_q : c_ram;

  // ---------------------------------------------------------------------------
  // Window cells: upper chain A <- B <- C, lower chain F <- E <- height
  // ---------------------------------------------------------------------------
  glms_pkg::cell_ctrl_t ctrl_a, ctrl_b, ctrl_e, ctrl_f;
  glms_pkg::height_t    win_a, win_b, win_e, win_f, fill_b;

  assign ctrl_a = '{load: state_q == ST_FILL3, shift: in_accept};
  assign ctrl_f = '{load: state_q == ST_FILL3, shift: in_accept};
  assign ctrl_e = '{load: state_q == ST_FILL4, shift: in_accept};
  assign ctrl_b = '{load: (state_q == ST_FILL4) || (in_accept && last_col),
                    shift: in_accept};
  assign fill_b = (state_q == ST_FILL4) ? c_ram : b_rowend;

  glms_cell u_cell_a (.clk_i(clk_i), .ctrl_i(ctrl_a), .nb_i(win_b),  .fill_i(c_ram),
                      .data_o(win_a));
  glms_cell u_cell_b (.clk_i(clk_i), .ctrl_i(ctrl_b), .nb_i(c_eff),  .fill_i(fill_b),
                      .data_o(win_b));
  glms_cell u_cell_e (.clk_i(clk_i), .ctrl_i(ctrl_e), .nb_i(height), .fill_i(d_ram),
                      .data_o(win_e));
  glms_cell u_cell_f (.clk_i(clk_i), .ctrl_i(ctrl_f), .nb_i(win_e),  .fill_i(d_ram),
                      .data_o(win_f));

  // ---------------------------------------------------------------------------
  // Low-point tests: cell above, last-row cell to the left, last-row cell itself
  // ---------------------------------------------------------------------------
  glms_pkg::nbr_t              nbr_above, nbr_left, nbr_self;
  logic                        low_above, low_left, low_self;
  logic [glms_pkg::HEIGHT_W:0] risk_above, risk_left, risk_self;

  assign nbr_above = '{center: win_b,
                       up:     row_ge2 ? d_ram : glms_pkg::EDGE_HEIGHT,
                       down:   height,
                       left:   col_ge1 ? win_a : glms_pkg::EDGE_HEIGHT,
                       right:  last_col ? glms_pkg::EDGE_HEIGHT : c_eff};
  assign nbr_left  = '{center: win_e,
                       up:     row_ge1 ? win_a : glms_pkg::EDGE_HEIGHT,
                       down:   glms_pkg::EDGE_HEIGHT,
                       left:   col_ge2 ? win_f : glms_pkg::EDGE_HEIGHT,
                       right:  height};
  assign nbr_self  = '{center: height,
                       up:     row_ge1 ? win_b : glms_pkg::EDGE_HEIGHT,
                       down:   glms_pkg::EDGE_HEIGHT,
                       left:   col_ge1 ? win_e : glms_pkg::EDGE_HEIGHT,
                       right:  glms_pkg::EDGE_HEIGHT};

  glms_judge u_judge_above (.en_i(row_ge1), .nbr_i(nbr_above), .low_o(low_above),
                            .risk_o(risk_above));
  glms_judge u_judge_left  (.en_i(last_row && col_ge1), .nbr_i(nbr_left),
                            .low_o(low_left), .risk_o(risk_left));
  glms_judge u_judge_self  (.en_i(frame_end), .nbr_i(nbr_self), .low_o(low_self),
                            .risk_o(risk_self));

  // ---------------------------------------------------------------------------
  // Accumulators
  // ---------------------------------------------------------------------------
  logic [glms_pkg::COUNT_W-1:0] count_q, count_next;
  logic [glms_pkg::RISK_W-1:0]  risk_q, risk_next;
  logic [1:0]                   count_inc;
  logic [IW-1:0]                risk_inc;

  assign count_inc  = 2'(low_above) + 2'(low_left) + 2'(low_self);
  assign risk_inc   = IW'(risk_above) + IW'(risk_left) + IW'(risk_self);
  assign count_next = count_q + glms_pkg::COUNT_W'(count_inc);
  assign risk_next  = risk_q + glms_pkg::RISK_W'(risk_inc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      risk_q  <= '0;
    end else if (in_accept) begin
      count_q <= frame_end ? '0 : count_next;
      risk_q  <= frame_end ? '0 : risk_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Two-word output queue: head drives the port, the second word absorbs a stall
  // ---------------------------------------------------------------------------
  result_t head_q, tail_q, new_word;
  logic    head_vld_q, tail_vld_q;
  logic    push, pop;

  assign new_word = '{low_count: count_next[glms_pkg::LOW_COUNT_W-1:0],
                      risk_sum:  risk_next};
  assign push     = in_accept && frame_end;
  assign pop      = head_vld_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
    end else begin
      priority if (pop && push) begin
        head_vld_q <= 1'b1;
        tail_vld_q <= tail_vld_q;
      end else if (pop) begin
        head_vld_q <= tail_vld_q;
        tail_vld_q <= 1'b0;
      end else if (push) begin
        head_vld_q <= 1'b1;
        tail_vld_q <= head_vld_q;
      end else begin
        head_vld_q <= head_vld_q;
        tail_vld_q <= tail_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (pop && push) begin
      head_q <= tail_vld_q ? tail_q : new_word;
      tail_q <= new_word;
    end else if (pop) begin
      head_q <= tail_q;
    end else if (push) begin
      if (head_vld_q) begin
        tail_q <= new_word;
      end else begin
        head_q <= new_word;
      end
    end else begin
      head_q <= head_q;
      tail_q <= tail_q;
    end
  end

  // Stall during a window reload, and stall a frame-closing word when the queue is full
  assign in_ready_o  = (state_q == ST_RUN) && !(frame_end && tail_vld_q);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = head_vld_q;
  assign low_count_o = head_q.low_count;
  assign risk_sum_o  = head_q.risk_sum;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_vld_q |-> head_vld_q)
    else $error("output queue holds a second word without a head word");

  a_reload_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_write |=> !in_ready_o)
    else $error("word taken while the window reloads");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && frame_end) |=> (count_q == '0) && (risk_q == '0) &&
                                 (row_index_q == '0) && (column_index_q == '0))
    else $error("frame counters not cleared after the last word");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (column_index_q <= $past(cols_m1)))
    else $error("column index ran past the row end");

  a_result_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && frame_end) |=> out_valid_o)
    else $error("frame result missing after the last word");

endmodule
